@@ hdl/i2cms_pkg.sv @@
// Shared types and code constants for the I2C write-then-read sequencer.
package i2cms_pkg;

    typedef logic [7:0] t_byte;

    // Item kinds
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;
    // unused kind, answered with an empty result
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    // Bus commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_ACK   = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_NACK  = 3'd4;
    localparam logic [2:0] CMD_RESET = 3'd5;

    // TWI status codes, low three bits masked
    localparam t_byte ST_BUS_ERROR    = 8'h00;
    localparam t_byte ST_START        = 8'h08;
    localparam t_byte ST_REP_START    = 8'h10;
    localparam t_byte ST_MT_SLA_ACK   = 8'h18;
    localparam t_byte ST_MT_SLA_NACK  = 8'h20;
    localparam t_byte ST_MT_DATA_ACK  = 8'h28;
    localparam t_byte ST_MT_DATA_NACK = 8'h30;
    localparam t_byte ST_ARB_LOST     = 8'h38;
    localparam t_byte ST_MR_SLA_ACK   = 8'h40;
    localparam t_byte ST_MR_SLA_NACK  = 8'h48;
    localparam t_byte ST_MR_DATA_ACK  = 8'h50;
    localparam t_byte ST_MR_DATA_NACK = 8'h58;

    // Configuration register indexes
    localparam logic [2:0] CFG_WRITE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_READ_ADDRESS  = 3'd1;
    localparam logic [2:0] CFG_WRITE_COUNT   = 3'd2;
    localparam logic [2:0] CFG_READ_COUNT    = 3'd3;

endpackage

@@ hdl/i2cms_buf.sv @@
// Transmit byte buffer: one write port, one registered read port, write-first.
module i2cms_buf #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  i2cms_pkg::t_byte         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output i2cms_pkg::t_byte         o_rd_data
);

    i2cms_pkg::t_byte r_mem [DEPTH];
    i2cms_pkg::t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // pass a same-edge write straight through to the read side
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/i2c_master_write_read_sequencer_core.sv @@
// An item passes through the input register and then the result register to its result.
// Throughput: one item per cycle; a stalled waiting result holds back the next item.
// The transmit buffer read is registered and addressed from the next state, so it keeps pace.
// Reset (synchronous, active low): idle, transmitter role, positions zero, registers at defaults.
// The transmit buffer is not cleared by reset; its slots hold nothing useful until loaded.
module i2c_master_write_read_sequencer_core #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [3:0] i_load_index,
    input  logic [7:0] i_load_byte,
    input  logic [7:0] i_bus_status,
    input  logic [7:0] i_rx_byte,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_command,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_rx_valid,
    output logic [3:0] o_rx_index,
    output logic [7:0] o_rx_data,
    output logic       o_transfer_done,
    output logic       o_start_refused,
    output logic       o_bad_sequence,
    output logic       o_bus_fault,
    output logic       o_short_read,
    output logic       o_receiver_role,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STARTED,
        PH_WAIT_WADDR,
        PH_WAIT_DATA,
        PH_SEND_RADDR,
        PH_WAIT_RADDR,
        PH_READ,
        PH_READ_FINAL
    } t_phase;

    typedef struct packed {
        logic [2:0]       command;
        logic             tx_valid;
        i2cms_pkg::t_byte tx_byte;
        logic             rx_valid;
        logic [3:0]       rx_index;
        i2cms_pkg::t_byte rx_data;
        logic             transfer_done;
        logic             start_refused;
        logic             bad_sequence;
        logic             bus_fault;
        logic             short_read;
        logic             receiver_role;
    } t_result;

    // Reduce a slot number modulo the buffer depth by conditional subtraction.
    function automatic logic [AW-1:0] f_slot(input logic [4:0] v);
        logic [12:0] r;
        r = {8'd0, v};
        for (int k = 4; k >= 0; k--) begin
            if (r >= 13'(BUFFER_DEPTH << k)) begin
                r = r - 13'(BUFFER_DEPTH << k);
            end
        end
        return r[AW-1:0];
    endfunction

    // configuration
    i2cms_pkg::t_byte r_write_address;
    i2cms_pkg::t_byte r_read_address;
    logic [4:0]       r_write_count;
    logic [4:0]       r_read_count;

    // sequencer state
    t_phase     r_phase,    n_phase;
    logic       r_role,     n_role;
    logic [4:0] r_wpos,     n_wpos;
    logic [4:0] r_rpos,     n_rpos;

    // input register
    logic             r_in_valid;
    logic [1:0]       r_in_mode;
    logic [3:0]       r_in_load_index;
    i2cms_pkg::t_byte r_in_load_byte;
    i2cms_pkg::t_byte r_in_bus_status;
    i2cms_pkg::t_byte r_in_rx_byte;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result c_res;

    logic             w_go;
    logic             w_bad;
    logic [4:0]       w_rpos_inc;
    i2cms_pkg::t_byte w_status;
    i2cms_pkg::t_byte w_buf_data;
    logic             w_buf_wr;
    logic [AW-1:0]    w_buf_rd_addr;

    assign w_go       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_go;
    assign o_cfg_ready = 1'b1;

    assign w_status   = r_in_bus_status & 8'hF8;
    assign w_rpos_inc = r_rpos + 5'd1;
    assign w_buf_wr   = w_go && (r_in_mode == i2cms_pkg::MODE_LOAD);
    // fetch the slot the next data-ack or address-ack will need
    assign w_buf_rd_addr = (n_phase == PH_WAIT_WADDR) ? '0 : f_slot(n_wpos);

    i2cms_buf #(
        .DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .i_clk    (i_clk),
        .i_wr_en  (w_buf_wr),
        .i_wr_addr(f_slot({1'b0, r_in_load_index})),
        .i_wr_data(r_in_load_byte),
        .i_rd_addr(w_buf_rd_addr),
        .o_rd_data(w_buf_data)
    );

    always_comb begin
        n_phase = r_phase;
        n_role  = r_role;
        n_wpos  = r_wpos;
        n_rpos  = r_rpos;
        c_res   = '0;
        w_bad   = 1'b0;
        if (w_go) begin
            unique case (r_in_mode)
                i2cms_pkg::MODE_LOAD: begin
                end
                i2cms_pkg::MODE_START: begin
                    if (r_phase == PH_IDLE) begin
                        c_res.command = i2cms_pkg::CMD_START;
                        n_phase = PH_STARTED;
                        n_wpos  = 5'd0;
                        n_rpos  = 5'd0;
                    end else begin
                        c_res.start_refused = 1'b1;
                    end
                end
                i2cms_pkg::MODE_STATUS: begin
                    unique case (w_status)
                        i2cms_pkg::ST_BUS_ERROR: begin
                            n_phase = PH_IDLE;
                            n_role  = 1'b0;
                            c_res.command   = i2cms_pkg::CMD_STOP;
                            c_res.bus_fault = 1'b1;
                        end
                        i2cms_pkg::ST_START, i2cms_pkg::ST_REP_START: begin
                            if (r_phase == PH_STARTED) begin
                                c_res.tx_valid = 1'b1;
                                c_res.tx_byte  = r_write_address;
                                c_res.command  = i2cms_pkg::CMD_ACK;
                                n_phase = PH_WAIT_WADDR;
                                n_role  = 1'b0;
                            end else if (r_phase == PH_SEND_RADDR) begin
                                c_res.tx_valid = 1'b1;
                                c_res.tx_byte  = r_read_address;
                                c_res.command  = i2cms_pkg::CMD_ACK;
                                n_phase = PH_WAIT_RADDR;
                                n_role  = 1'b1;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MT_SLA_ACK: begin
                            if (r_phase == PH_WAIT_WADDR) begin
                                c_res.tx_valid = 1'b1;
                                c_res.tx_byte  = w_buf_data;
                                c_res.command  = i2cms_pkg::CMD_ACK;
                                n_phase = PH_WAIT_DATA;
                                n_wpos  = 5'd1;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MT_SLA_NACK: begin
                            if (r_phase == PH_WAIT_WADDR) begin
                                n_phase = PH_IDLE;
                                n_role  = 1'b0;
                                c_res.command = i2cms_pkg::CMD_RESET;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MT_DATA_NACK: begin
                            if (r_phase == PH_WAIT_DATA) begin
                                n_phase = PH_IDLE;
                                n_role  = 1'b0;
                                c_res.command = i2cms_pkg::CMD_RESET;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MT_DATA_ACK: begin
                            if (r_phase != PH_WAIT_DATA) begin
                                w_bad = 1'b1;
                            end else if (r_wpos >= r_write_count) begin
                                c_res.command = i2cms_pkg::CMD_START;
                                n_phase = PH_SEND_RADDR;
                            end else begin
                                c_res.tx_valid = 1'b1;
                                c_res.tx_byte  = w_buf_data;
                                c_res.command  = i2cms_pkg::CMD_ACK;
                                n_wpos = r_wpos + 5'd1;
                                n_role = 1'b0;
                            end
                        end
                        i2cms_pkg::ST_ARB_LOST: begin
                            // retry the whole transaction
                            n_phase = PH_STARTED;
                            n_role  = 1'b0;
                            n_wpos  = 5'd0;
                            n_rpos  = 5'd0;
                            c_res.command = i2cms_pkg::CMD_START;
                        end
                        i2cms_pkg::ST_MR_SLA_ACK: begin
                            if (r_phase == PH_WAIT_RADDR) begin
                                n_phase = PH_READ;
                                c_res.command = i2cms_pkg::CMD_ACK;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MR_SLA_NACK: begin
                            if (r_phase == PH_WAIT_RADDR) begin
                                c_res.tx_valid = 1'b1;
                                c_res.tx_byte  = r_read_address;
                                c_res.command  = i2cms_pkg::CMD_ACK;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MR_DATA_ACK: begin
                            if (r_phase == PH_READ) begin
                                c_res.rx_valid = 1'b1;
                                c_res.rx_index = r_rpos[3:0];
                                c_res.rx_data  = r_in_rx_byte;
                                n_rpos = w_rpos_inc;
                                if (({1'b0, w_rpos_inc} + 6'd1) == {1'b0, r_read_count}) begin
                                    c_res.command = i2cms_pkg::CMD_NACK;
                                    n_phase = PH_READ_FINAL;
                                end else if (w_rpos_inc >= r_read_count) begin
                                    n_phase = PH_IDLE;
                                    n_role  = 1'b0;
                                    c_res.command       = i2cms_pkg::CMD_STOP;
                                    c_res.transfer_done = 1'b1;
                                end else begin
                                    c_res.command = i2cms_pkg::CMD_ACK;
                                end
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        i2cms_pkg::ST_MR_DATA_NACK: begin
                            if (r_phase == PH_READ_FINAL) begin
                                c_res.rx_valid = 1'b1;
                                c_res.rx_index = r_rpos[3:0];
                                c_res.rx_data  = r_in_rx_byte;
                                c_res.short_read    = (w_rpos_inc != r_read_count);
                                c_res.command       = i2cms_pkg::CMD_STOP;
                                c_res.transfer_done = 1'b1;
                                n_rpos  = w_rpos_inc;
                                n_phase = PH_IDLE;
                                n_role  = 1'b0;
                            end else begin
                                w_bad = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
            if (w_bad) begin
                // drop the whole answer, flag it, keep the state
                c_res = '0;
                c_res.bad_sequence = 1'b1;
            end
        end
        c_res.receiver_role = n_role;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_address <= 8'd0;
            r_read_address  <= 8'd1;
            r_write_count   <= 5'd1;
            r_read_count    <= 5'd1;
            r_phase         <= PH_IDLE;
            r_role          <= 1'b0;
            r_wpos          <= 5'd0;
            r_rpos          <= 5'd0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    i2cms_pkg::CFG_WRITE_ADDRESS: r_write_address <= i_cfg_data;
                    i2cms_pkg::CFG_READ_ADDRESS:  r_read_address  <= i_cfg_data;
                    i2cms_pkg::CFG_WRITE_COUNT:   r_write_count   <= i_cfg_data[4:0];
                    i2cms_pkg::CFG_READ_COUNT:    r_read_count    <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            r_phase <= n_phase;
            r_role  <= n_role;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_mode       <= i_mode;
            r_in_load_index <= i_load_index;
            r_in_load_byte  <= i_load_byte;
            r_in_bus_status <= i_bus_status;
            r_in_rx_byte    <= i_rx_byte;
        end
        if (w_go) begin
            r_out <= c_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command       = r_out.command;
    assign o_tx_valid      = r_out.tx_valid;
    assign o_tx_byte       = r_out.tx_byte;
    assign o_rx_valid      = r_out.rx_valid;
    assign o_rx_index      = r_out.rx_index;
    assign o_rx_data       = r_out.rx_data;
    assign o_transfer_done = r_out.transfer_done;
    assign o_start_refused = r_out.start_refused;
    assign o_bad_sequence  = r_out.bad_sequence;
    assign o_bus_fault     = r_out.bus_fault;
    assign o_short_read    = r_out.short_read;
    assign o_receiver_role = r_out.receiver_role;

    a_idle_is_transmitter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> !r_role)
        else $error("receiver role held while idle");

    a_bad_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_sequence |->
            o_command == i2cms_pkg::CMD_NONE && !o_tx_valid && !o_rx_valid)
        else $error("bad sequence result carries a command or byte");

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transfer_done |->
            o_command == i2cms_pkg::CMD_STOP && o_rx_valid && !o_receiver_role)
        else $error("transfer done without stop and final byte");

    a_load_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && r_in_mode == i2cms_pkg::MODE_LOAD |=> $stable(r_phase))
        else $error("buffer load moved the phase");

    a_result_taken_or_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> o_out_valid)
        else $error("processed item produced no result");

endmodule
